FILE: hdl/segment_grid_traversal_macros.svh
// ----------------------------------------------------------------------------
// Segment grid traversal assertion macros
// Checks that are compiled for simulation and drop out of synthesis.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_GRID_TRAVERSAL_MACROS_SVH
`define SEGMENT_GRID_TRAVERSAL_MACROS_SVH

`ifndef SYNTHESIS
`define SGT_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sgt same-cycle check failed");
`define SGT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sgt next-cycle check failed");
`else
`define SGT_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SGT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hdl/sgt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment grid traversal package
// Widths, codes and item types shared by the walker and the top level.
// ----------------------------------------------------------------------------
package sgt_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int INT_BITS    = 12;
    localparam int IN_W        = INT_BITS + FRAC_BITS;
    localparam int DIFF_W      = IN_W + 1;
    localparam int NEAR_W      = FRAC_BITS + 1;
    localparam int PROD_W      = NEAR_W + DIFF_W;
    localparam int INCR_W      = DIFF_W + FRAC_BITS;
    localparam int CROSS_W     = 42;
    localparam int SPAN_W      = INT_BITS + 1;
    localparam int MOVES_W     = 14;
    localparam int LIMIT_SLACK = 2;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef enum logic {
        FUNC_START   = 1'b0,
        FUNC_ADVANCE = 1'b1
    } func_t;

    typedef struct packed {
        func_t                  func;
        logic signed [IN_W-1:0] start_x;
        logic signed [IN_W-1:0] start_y;
        logic signed [IN_W-1:0] end_x;
        logic signed [IN_W-1:0] end_y;
    } item_t;

    typedef struct packed {
        logic                valid_res;
        logic [INT_BITS-1:0] texel_x;
        logic [INT_BITS-1:0] texel_y;
        logic                last;
    } result_t;

endpackage

FILE: hdl/sgt_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment grid traversal walker
// Holds the walk state and produces one result per processed item; an advance while idle gives an empty one.
// ----------------------------------------------------------------------------
`include "segment_grid_traversal_macros.svh"

module sgt_walk (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  sgt_pkg::item_t   item,
    output sgt_pkg::result_t res
);

    logic                                 walk_active_reg, walk_active_next;
    logic        [sgt_pkg::INT_BITS-1:0]  cur_col_reg, cur_col_next;
    logic        [sgt_pkg::INT_BITS-1:0]  cur_row_reg, cur_row_next;
    logic        [sgt_pkg::INT_BITS-1:0]  goal_col_reg, goal_col_next;
    logic        [sgt_pkg::INT_BITS-1:0]  goal_row_reg, goal_row_next;
    logic        [1:0]                    dir_x_reg, dir_x_next;
    logic        [1:0]                    dir_y_reg, dir_y_next;
    logic        [sgt_pkg::CROSS_W-1:0]   cross_x_reg, cross_x_next;
    logic        [sgt_pkg::CROSS_W-1:0]   cross_y_reg, cross_y_next;
    logic        [sgt_pkg::INCR_W-1:0]    incr_x_reg, incr_x_next;
    logic        [sgt_pkg::INCR_W-1:0]    incr_y_reg, incr_y_next;
    logic        [sgt_pkg::MOVES_W-1:0]   moves_left_reg, moves_left_next;

    logic signed [sgt_pkg::DIFF_W-1:0]    dx, dy;
    logic        [sgt_pkg::DIFF_W-1:0]    adx, ady;
    logic        [sgt_pkg::INT_BITS-1:0]  col0, row0, gcol0, grow0;
    logic        [sgt_pkg::NEAR_W-1:0]    nx, ny;
    logic        [sgt_pkg::PROD_W-1:0]    prod_x, prod_y;
    logic signed [sgt_pkg::SPAN_W-1:0]    span_col, span_row;
    logic        [sgt_pkg::SPAN_W-1:0]    mag_col, mag_row;
    logic        [1:0]                    dir_x0, dir_y0;
    logic                                 start_fin;
    logic                                 pick_x;
    logic        [sgt_pkg::INT_BITS-1:0]  step_col, step_row;
    logic        [sgt_pkg::MOVES_W-1:0]   moves_dec;
    logic                                 adv_fin;

    always_comb begin
        dx = $signed({item.end_x[sgt_pkg::IN_W-1], item.end_x})
           - $signed({item.start_x[sgt_pkg::IN_W-1], item.start_x});
        dy = $signed({item.end_y[sgt_pkg::IN_W-1], item.end_y})
           - $signed({item.start_y[sgt_pkg::IN_W-1], item.start_y});
        adx = dx[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIFF_W'(-dx) : sgt_pkg::DIFF_W'(dx);
        ady = dy[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIFF_W'(-dy) : sgt_pkg::DIFF_W'(dy);

        col0  = item.start_x[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
        row0  = item.start_y[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
        gcol0 = item.end_x[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
        grow0 = item.end_y[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];

        dir_x0 = (dx == '0) ? sgt_pkg::DIR_NONE
               : (dx[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIR_NEG : sgt_pkg::DIR_POS);
        dir_y0 = (dy == '0) ? sgt_pkg::DIR_NONE
               : (dy[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIR_NEG : sgt_pkg::DIR_POS);

        nx = (dir_x0 == sgt_pkg::DIR_POS)
           ? (sgt_pkg::NEAR_W'(1) << sgt_pkg::FRAC_BITS)
             - {1'b0, item.start_x[sgt_pkg::FRAC_BITS-1:0]}
           : {1'b0, item.start_x[sgt_pkg::FRAC_BITS-1:0]};
        ny = (dir_y0 == sgt_pkg::DIR_POS)
           ? (sgt_pkg::NEAR_W'(1) << sgt_pkg::FRAC_BITS)
             - {1'b0, item.start_y[sgt_pkg::FRAC_BITS-1:0]}
           : {1'b0, item.start_y[sgt_pkg::FRAC_BITS-1:0]};
        prod_x = sgt_pkg::PROD_W'(nx) * sgt_pkg::PROD_W'(ady);
        prod_y = sgt_pkg::PROD_W'(ny) * sgt_pkg::PROD_W'(adx);

        span_col = $signed({gcol0[sgt_pkg::INT_BITS-1], gcol0})
                 - $signed({col0[sgt_pkg::INT_BITS-1], col0});
        span_row = $signed({grow0[sgt_pkg::INT_BITS-1], grow0})
                 - $signed({row0[sgt_pkg::INT_BITS-1], row0});
        mag_col = span_col[sgt_pkg::SPAN_W-1] ? sgt_pkg::SPAN_W'(-span_col)
                                              : sgt_pkg::SPAN_W'(span_col);
        mag_row = span_row[sgt_pkg::SPAN_W-1] ? sgt_pkg::SPAN_W'(-span_row)
                                              : sgt_pkg::SPAN_W'(span_row);
        start_fin = (col0 == gcol0) && (row0 == grow0);

        pick_x = (dir_x_reg != sgt_pkg::DIR_NONE)
              && ((dir_y_reg == sgt_pkg::DIR_NONE) || (cross_x_reg < cross_y_reg));
        step_col = cur_col_reg
                 + {{(sgt_pkg::INT_BITS-2){dir_x_reg[1]}}, dir_x_reg};
        step_row = cur_row_reg
                 + {{(sgt_pkg::INT_BITS-2){dir_y_reg[1]}}, dir_y_reg};
        moves_dec = (moves_left_reg != '0) ? moves_left_reg - sgt_pkg::MOVES_W'(1)
                                           : moves_left_reg;
    end

    always_comb begin
        walk_active_next = walk_active_reg;
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        goal_col_next    = goal_col_reg;
        goal_row_next    = goal_row_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        cross_x_next     = cross_x_reg;
        cross_y_next     = cross_y_reg;
        incr_x_next      = incr_x_reg;
        incr_y_next      = incr_y_reg;
        moves_left_next  = moves_left_reg;
        adv_fin          = 1'b0;
        res              = '0;

        if (item.func == sgt_pkg::FUNC_START) begin
            cur_col_next     = col0;
            cur_row_next     = row0;
            goal_col_next    = gcol0;
            goal_row_next    = grow0;
            dir_x_next       = dir_x0;
            dir_y_next       = dir_y0;
            cross_x_next     = sgt_pkg::CROSS_W'(prod_x);
            cross_y_next     = sgt_pkg::CROSS_W'(prod_y);
            incr_x_next      = {ady, sgt_pkg::FRAC_BITS'(0)};
            incr_y_next      = {adx, sgt_pkg::FRAC_BITS'(0)};
            moves_left_next  = sgt_pkg::MOVES_W'(mag_col) + sgt_pkg::MOVES_W'(mag_row)
                             + sgt_pkg::MOVES_W'(sgt_pkg::LIMIT_SLACK);
            walk_active_next = !start_fin;
            res.valid_res    = 1'b1;
            res.texel_x      = col0;
            res.texel_y      = row0;
            res.last         = start_fin;
        end else if (walk_active_reg) begin
            if (pick_x) begin
                cur_col_next = step_col;
                cross_x_next = cross_x_reg + sgt_pkg::CROSS_W'(incr_x_reg);
            end else begin
                cur_row_next = step_row;
                cross_y_next = cross_y_reg + sgt_pkg::CROSS_W'(incr_y_reg);
            end
            moves_left_next = moves_dec;
            adv_fin = ((cur_col_next == goal_col_reg) && (cur_row_next == goal_row_reg))
                   || (moves_dec == '0);
            walk_active_next = !adv_fin;
            res.valid_res    = 1'b1;
            res.texel_x      = cur_col_next;
            res.texel_y      = cur_row_next;
            res.last         = adv_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            walk_active_reg <= 1'b0;
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            goal_col_reg    <= '0;
            goal_row_reg    <= '0;
            dir_x_reg       <= sgt_pkg::DIR_NONE;
            dir_y_reg       <= sgt_pkg::DIR_NONE;
            cross_x_reg     <= '0;
            cross_y_reg     <= '0;
            incr_x_reg      <= '0;
            incr_y_reg      <= '0;
            moves_left_reg  <= '0;
        end else if (step_en) begin
            walk_active_reg <= walk_active_next;
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            goal_col_reg    <= goal_col_next;
            goal_row_reg    <= goal_row_next;
            dir_x_reg       <= dir_x_next;
            dir_y_reg       <= dir_y_next;
            cross_x_reg     <= cross_x_next;
            cross_y_reg     <= cross_y_next;
            incr_x_reg      <= incr_x_next;
            incr_y_reg      <= incr_y_next;
            moves_left_reg  <= moves_left_next;
        end
    end

    `SGT_ASSERT_SAME(a_active_has_moves, aclk, aresetn, walk_active_reg, moves_left_reg != '0)
    `SGT_ASSERT_SAME(a_idle_advance_empty, aclk, aresetn, step_en && (item.func == sgt_pkg::FUNC_ADVANCE) && !walk_active_reg, !res.valid_res && !res.last)
    `SGT_ASSERT_NEXT(a_last_ends_walk, aclk, aresetn, step_en && res.last, !walk_active_reg)
    `SGT_ASSERT_NEXT(a_open_start_walks, aclk, aresetn, step_en && (item.func == sgt_pkg::FUNC_START) && !res.last, walk_active_reg)

endmodule

FILE: hdl/segment_grid_traversal.sv
`timescale 1ns / 1ps
// Each accepted input item is held in the input register, then its result in the result register.
// One item per cycle while m_tready does not hold a result; each advance is one compare and add on the running sums.
// Input and result stages each hold one item, so input is taken while a result waits only if the input stage is empty.
// Reset (aresetn low, synchronous) empties both stages and idles the walk.
// ----------------------------------------------------------------------------
// Segment grid traversal
// Walks the unit texel grid along a fixed-point segment, at most one texel per item.
// ----------------------------------------------------------------------------
module segment_grid_traversal (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // start_x[19:0], start_y[39:20], end_x[59:40], end_y[79:60]
    input  logic [0:0]  s_tuser,   // func[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // texel_x[11:0], texel_y[23:12]
    output logic [0:0]  m_tuser,   // valid_res[0]
    output logic        m_tlast
);

    localparam int IW = sgt_pkg::IN_W;

    logic               in_vld_reg, in_vld_next;
    sgt_pkg::item_t     in_item_reg;
    logic               out_vld_reg, out_vld_next;
    sgt_pkg::result_t   out_res_reg;
    sgt_pkg::result_t   step_res;
    logic               fire;

    assign fire     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || fire;

    always_comb begin
        in_vld_next  = s_tready ? s_tvalid : in_vld_reg;
        out_vld_next = fire ? 1'b1 : (out_vld_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.func    <= sgt_pkg::func_t'(s_tuser[0]);
            in_item_reg.start_x <= s_tdata[IW-1:0];
            in_item_reg.start_y <= s_tdata[2*IW-1:IW];
            in_item_reg.end_x   <= s_tdata[3*IW-1:2*IW];
            in_item_reg.end_y   <= s_tdata[4*IW-1:3*IW];
        end
        if (fire) begin
            out_res_reg <= step_res;
        end
    end

    sgt_walk u_walk (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_item_reg),
        .res     (step_res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_res_reg.texel_y, out_res_reg.texel_x};
    assign m_tuser  = out_res_reg.valid_res;
    assign m_tlast  = out_res_reg.last;

endmodule

FILE: verif/segment_grid_traversal_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment grid traversal testbench
// Drives start and advance items into the texel walker, predicts each texel
// with an exact integer stepping model, and checks every result in order.
// ----------------------------------------------------------------------------
module segment_grid_traversal_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SPREAD      = 1536;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC
    } ready_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;   // start_x[19:0], start_y[39:20], end_x[59:40], end_y[79:60]
    logic [0:0]  s_tuser;   // func[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;   // texel_x[11:0], texel_y[23:12]
    logic [0:0]  m_tuser;   // valid_res[0]
    logic        m_tlast;

    segment_grid_traversal uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // walker state as predicted
    logic                                walking      = 1'b0;
    logic signed [sgt_pkg::INT_BITS-1:0] col_now      = '0;
    logic signed [sgt_pkg::INT_BITS-1:0] row_now      = '0;
    logic signed [sgt_pkg::INT_BITS-1:0] col_goal     = '0;
    logic signed [sgt_pkg::INT_BITS-1:0] row_goal     = '0;
    logic [1:0]                          step_x       = sgt_pkg::DIR_NONE;
    logic [1:0]                          step_y       = sgt_pkg::DIR_NONE;
    logic [sgt_pkg::CROSS_W-1:0]         dist_x       = '0;
    logic [sgt_pkg::CROSS_W-1:0]         dist_y       = '0;
    logic [sgt_pkg::INCR_W-1:0]          gain_x       = '0;
    logic [sgt_pkg::INCR_W-1:0]          gain_y       = '0;
    logic [sgt_pkg::MOVES_W-1:0]         moves_budget = '0;

    sgt_pkg::result_t texels_due[$];
    sgt_pkg::result_t texel_want;
    sgt_pkg::result_t texel_seen;
    int               texels_predicted = 0;
    int               mismatches = 0;
    int               cycle_count = 0;
    int               burst_left = 0;
    int               gap_max = 0;
    ready_mode_t      ready_mode = READY_ALWAYS;
    int               stall_phase = 0;
    int               stall_period = 7;
    int               stall_low = 3;

    function automatic sgt_pkg::result_t predict_texel(input sgt_pkg::item_t it);
        sgt_pkg::result_t                   r;
        logic signed [sgt_pkg::DIFF_W-1:0]  dx;
        logic signed [sgt_pkg::DIFF_W-1:0]  dy;
        logic [sgt_pkg::DIFF_W-1:0]         adx;
        logic [sgt_pkg::DIFF_W-1:0]         ady;
        logic [sgt_pkg::NEAR_W-1:0]         nx;
        logic [sgt_pkg::NEAR_W-1:0]         ny;
        int                                 dc;
        int                                 dr;
        logic                               fin;
        r = '0;
        if (it.func == sgt_pkg::FUNC_START) begin
            dx = {it.end_x[sgt_pkg::IN_W-1], it.end_x}
               - {it.start_x[sgt_pkg::IN_W-1], it.start_x};
            dy = {it.end_y[sgt_pkg::IN_W-1], it.end_y}
               - {it.start_y[sgt_pkg::IN_W-1], it.start_y};
            adx = dx[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIFF_W'(-dx) : dx;
            ady = dy[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIFF_W'(-dy) : dy;
            col_now  = it.start_x[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
            row_now  = it.start_y[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
            col_goal = it.end_x[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
            row_goal = it.end_y[sgt_pkg::IN_W-1:sgt_pkg::FRAC_BITS];
            step_x = dx[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIR_NEG
                   : ((dx != 0) ? sgt_pkg::DIR_POS : sgt_pkg::DIR_NONE);
            step_y = dy[sgt_pkg::DIFF_W-1] ? sgt_pkg::DIR_NEG
                   : ((dy != 0) ? sgt_pkg::DIR_POS : sgt_pkg::DIR_NONE);
            nx = sgt_pkg::NEAR_W'(it.start_x[sgt_pkg::FRAC_BITS-1:0]);
            ny = sgt_pkg::NEAR_W'(it.start_y[sgt_pkg::FRAC_BITS-1:0]);
            if (step_x == sgt_pkg::DIR_POS)
                nx = (sgt_pkg::NEAR_W'(1) << sgt_pkg::FRAC_BITS) - nx;
            if (step_y == sgt_pkg::DIR_POS)
                ny = (sgt_pkg::NEAR_W'(1) << sgt_pkg::FRAC_BITS) - ny;
            dist_x = sgt_pkg::CROSS_W'(nx) * sgt_pkg::CROSS_W'(ady);
            dist_y = sgt_pkg::CROSS_W'(ny) * sgt_pkg::CROSS_W'(adx);
            gain_x = sgt_pkg::INCR_W'(ady) << sgt_pkg::FRAC_BITS;
            gain_y = sgt_pkg::INCR_W'(adx) << sgt_pkg::FRAC_BITS;
            dc = int'(col_goal) - int'(col_now);
            dr = int'(row_goal) - int'(row_now);
            moves_budget = sgt_pkg::MOVES_W'((dc < 0 ? -dc : dc) + (dr < 0 ? -dr : dr)
                                             + sgt_pkg::LIMIT_SLACK);
            fin = (col_now == col_goal) && (row_now == row_goal);
            walking = !fin;
        end else if (!walking) begin
            return r;
        end else begin
            if (step_x != sgt_pkg::DIR_NONE
                && (step_y == sgt_pkg::DIR_NONE || dist_x < dist_y)) begin
                if (step_x == sgt_pkg::DIR_POS)
                    col_now = col_now + 1'b1;
                else
                    col_now = col_now - 1'b1;
                dist_x = dist_x + gain_x;
            end else begin
                if (step_y == sgt_pkg::DIR_POS)
                    row_now = row_now + 1'b1;
                else if (step_y == sgt_pkg::DIR_NEG)
                    row_now = row_now - 1'b1;
                dist_y = dist_y + gain_y;
            end
            if (moves_budget != 0)
                moves_budget = moves_budget - 1'b1;
            fin = (col_now == col_goal && row_now == row_goal) || moves_budget == 0;
            if (fin)
                walking = 1'b0;
        end
        r.valid_res = 1'b1;
        r.texel_x   = col_now;
        r.texel_y   = row_now;
        r.last      = fin;
        return r;
    endfunction

    function automatic sgt_pkg::item_t make_start(input int ax, input int ay,
                                                  input int bx, input int by);
        sgt_pkg::item_t it;
        it.func    = sgt_pkg::FUNC_START;
        it.start_x = sgt_pkg::IN_W'(ax);
        it.start_y = sgt_pkg::IN_W'(ay);
        it.end_x   = sgt_pkg::IN_W'(bx);
        it.end_y   = sgt_pkg::IN_W'(by);
        return it;
    endfunction

    function automatic sgt_pkg::item_t advance_item();
        sgt_pkg::item_t it;
        it.func    = sgt_pkg::FUNC_ADVANCE;
        it.start_x = sgt_pkg::IN_W'($urandom);
        it.start_y = sgt_pkg::IN_W'($urandom);
        it.end_x   = sgt_pkg::IN_W'($urandom);
        it.end_y   = sgt_pkg::IN_W'($urandom);
        return it;
    endfunction

    task automatic send_item(input sgt_pkg::item_t it);
        sgt_pkg::result_t r;
        int               gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {it.end_y, it.end_x, it.start_y, it.start_x};
        s_tuser  <= it.func;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        r = predict_texel(it);
        texels_due = {texels_due, r};
        if (r.valid_res)
            texels_predicted++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic walk_out();
        while (walking)
            send_item(advance_item());
    endtask

    task automatic test_idle_advance();
        send_item(advance_item());
        send_item(advance_item());
    endtask

    task automatic test_extremes();
        send_item(make_start(-524288, -524288, 524287, 524287));
        send_item(advance_item());
        send_item(advance_item());
        send_item(make_start(524287, 524287, -524288, -524288));
        send_item(advance_item());
        send_item(advance_item());
        send_item(make_start(524287, -524288, -524288, 524287));
        send_item(advance_item());
    endtask

    task automatic test_single_texel();
        send_item(make_start(16, 16, 240, 240));
        send_item(advance_item());
    endtask

    task automatic test_axis_aligned();
        send_item(make_start(3 * 256 + 10, 5 * 256 + 128, 7 * 256 + 200, 5 * 256 + 3));
        send_item(advance_item());
        send_item(advance_item());
        send_item(make_start(100, 4 * 256 + 50, 100, -256));
        walk_out();
        send_item(advance_item());
    endtask

    task automatic test_ties_and_limit();
        send_item(make_start(128, 128, 640, 640));
        walk_out();
        send_item(make_start(128, 640, 512, 256));
        walk_out();
    endtask

    function automatic int near_coord();
        return int'($urandom_range(0, 1044479)) - 524288 + 2048;
    endfunction

    task automatic test_random_walks(input int n, input int gaps, input ready_mode_t mode);
        int             target;
        int             pick;
        int             ax, ay, bx, by;
        sgt_pkg::item_t it;
        target = texels_predicted + n;
        gap_max = gaps;
        ready_mode <= mode;
        stall_period <= $urandom_range(3, 9);
        stall_low <= $urandom_range(1, 2);
        while (texels_predicted < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                ax = near_coord();
                ay = near_coord();
                bx = ax + int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
                by = ay + int'($urandom_range(0, 2 * SPREAD)) - SPREAD;
                if ($urandom_range(0, 6) == 0)
                    bx = ax;
                else if ($urandom_range(0, 6) == 0)
                    by = ay;
                if ($urandom_range(0, 5) == 0) begin
                    ax = ax & ~32'hFF;
                    by = by & ~32'hFF;
                end
                send_item(make_start(ax, ay, bx, by));
                while (walking) begin
                    if ($urandom_range(0, 19) == 0)
                        break;
                    send_item(advance_item());
                end
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) send_item(advance_item());
            end else if (pick < 90) begin
                send_item(make_start($urandom, $urandom, $urandom, $urandom));
                repeat ($urandom_range(1, 4)) send_item(advance_item());
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    it = advance_item();
                    it.func = sgt_pkg::func_t'($urandom_range(0, 1));
                    send_item(it);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        case (ready_mode)
            READY_ALWAYS:   m_tready <= 1'b1;
            READY_RANDOM:   m_tready <= ($urandom_range(0, 3) != 0);
            READY_PERIODIC: m_tready <= (stall_phase % stall_period) >= stall_low;
            default:        m_tready <= 1'b1;
        endcase
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            texel_seen.valid_res = m_tuser[0];
            texel_seen.texel_x   = m_tdata[11:0];
            texel_seen.texel_y   = m_tdata[23:12];
            texel_seen.last      = m_tlast;
            if (texels_due.size() == 0) begin
                $display("%0t ns: unexpected texel x=%0d y=%0d", $time,
                         $signed(texel_seen.texel_x), $signed(texel_seen.texel_y));
                mismatches++;
            end else begin
                texel_want = texels_due.pop_front();
                report_field("valid_res", texel_want.valid_res, texel_seen.valid_res);
                report_field("texel_x", int'($signed(texel_want.texel_x)),
                             int'($signed(texel_seen.texel_x)));
                report_field("texel_y", int'($signed(texel_want.texel_y)),
                             int'($signed(texel_seen.texel_y)));
                report_field("last", texel_want.last, texel_seen.last);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = sgt_pkg::FUNC_START;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_advance();
        test_extremes();
        test_single_texel();
        test_axis_aligned();
        test_ties_and_limit();
        test_random_walks(150, 0, READY_ALWAYS);
        test_random_walks(300, 6, READY_PERIODIC);
        test_random_walks(150, 12, READY_RANDOM);
        s_tvalid <= 1'b0;
        while (texels_due.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
